### src/tpsnq_pkg.sv
// Shared types and codes for the typed point store with nearest-point query.
package tpsnq_pkg;

  localparam int COORD_BITS = 10;
  localparam int DIST_BITS  = COORD_BITS + 1;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  res_type;
    logic [9:0]  coord_x;
    logic [9:0]  coord_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  near_x;
    logic [9:0]  near_y;
    logic [10:0] near_dist;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

endpackage

### src/typed_point_store_nearest_query.sv
// Insert, clear and an out-of-range type go from S_EXEC straight to S_FIN; a query or a
// remove scans the list of its type in S_SCAN, with one point-memory read per cycle, and a
// remove that hits entry h then moves the last entry into it through S_MVRD and S_MVWR.
// One item at a time: the next input is taken in the cycle after the result is loaded into
// the output register, so the input is stalled for a whole scan and while the output stalls.
// Reset empties all lists; point memory is not cleared.
module typed_point_store_nearest_query
  import tpsnq_pkg::*;
#(
  parameter int NUM_TYPES     = 8,
  parameter int LIST_CAPACITY = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int DEPTH  = NUM_TYPES * LIST_CAPACITY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(LIST_CAPACITY + 1);
  localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_SCAN = 6'b000100,
    S_MVRD = 6'b001000,
    S_MVWR = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]            act_r, act_nxt;
  logic [TYPE_W-1:0]     type_r, type_nxt;
  logic                  type_ok_r, type_ok_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic                  found_r, found_nxt;
  logic [DIST_BITS-1:0]  best_r, best_nxt;
  out_item_t             res_r, res_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0] list_cnt_r [NUM_TYPES];
  logic             cnt_we, cnt_clr;
  logic [CNT_W-1:0] cnt_wval;

  point_t            mem [DEPTH];
  point_t            rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  point_t            mem_wdata;

  logic [COORD_BITS-1:0] dx, dy;
  logic [DIST_BITS-1:0]  pt_dist;
  logic                  in_type_ok;
  logic [TYPE_W-1:0]     in_type;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_type_ok = (int'(in_data.res_type) < NUM_TYPES);
  assign in_type    = TYPE_W'(in_data.res_type);

  // Shared distance unit on the point just read.
  always_comb begin
    dx      = (px_r >= rd_q.x) ? (px_r - rd_q.x) : (rd_q.x - px_r);
    dy      = (py_r >= rd_q.y) ? (py_r - rd_q.y) : (rd_q.y - py_r);
    pt_dist = {1'b0, dx} + {1'b0, dy};
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    type_nxt      = type_r;
    type_ok_nxt   = type_ok_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    hit_idx_nxt   = hit_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cnt_we        = 1'b0;
    cnt_clr       = 1'b0;
    cnt_wval      = cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = base_r + ADDR_W'(cnt_r);
    mem_wdata     = '{x: px_r, y: py_r};
    mem_re        = 1'b0;
    mem_raddr     = base_r + ADDR_W'(idx_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_data.action;
          type_nxt    = in_type;
          type_ok_nxt = in_type_ok;
          px_nxt      = in_data.coord_x[COORD_BITS-1:0];
          py_nxt      = in_data.coord_y[COORD_BITS-1:0];
          cnt_nxt     = in_type_ok ? list_cnt_r[in_type] : '0;
          base_nxt    = ADDR_W'(int'(in_type) * LIST_CAPACITY);
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt     = '0;
        found_nxt   = 1'b0;
        best_nxt    = '0;
        idx_nxt     = '0;
        state_nxt   = S_FIN;
        if (act_r == ACT_CLEAR) begin
          cnt_clr        = 1'b1;
          res_nxt.status = ST_OK;
        end else if (!type_ok_r) begin
          res_nxt.status = (act_r == ACT_INSERT) ? ST_FULL : ST_NONE;
        end else if (act_r == ACT_INSERT) begin
          if (int'(cnt_r) >= LIST_CAPACITY) begin
            res_nxt.status = ST_FULL;
          end else begin
            mem_we         = 1'b1;
            cnt_we         = 1'b1;
            cnt_wval       = cnt_r + CNT_W'(1);
            res_nxt.status = ST_OK;
          end
        end else begin
          res_nxt.status = ST_NONE;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue the next read while the previous point is checked.
        if (idx_r < cnt_r) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt    = idx_r + CNT_W'(1);
        end
        if (rd_vld_r && act_r == ACT_REMOVE && rd_q.x == px_r && rd_q.y == py_r) begin
          hit_idx_nxt = rd_idx_r;
          rd_vld_nxt  = 1'b0;
          state_nxt   = S_MVRD;
        end else begin
          if (rd_vld_r && act_r == ACT_QUERY && (!found_r || pt_dist < best_r)) begin
            found_nxt      = 1'b1;
            best_nxt       = pt_dist;
            res_nxt.near_x = 10'(rd_q.x);
            res_nxt.near_y = 10'(rd_q.y);
          end
          if (!rd_vld_r && idx_r >= cnt_r) begin
            // Scan done.
            if (act_r == ACT_QUERY && found_r) begin
              res_nxt.status    = ST_OK;
              res_nxt.near_dist = 11'(best_r);
            end else begin
              res_nxt = '0;
              res_nxt.status = ST_NONE;
            end
            state_nxt = S_FIN;
          end
        end
      end
      S_MVRD: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + ADDR_W'(cnt_r - CNT_W'(1));
        state_nxt = S_MVWR;
      end
      S_MVWR: begin
        // Move the last entry into the freed slot and shrink the list.
        mem_we         = 1'b1;
        mem_waddr      = base_r + ADDR_W'(hit_idx_r);
        mem_wdata      = rd_q;
        cnt_we         = 1'b1;
        cnt_wval       = cnt_r - CNT_W'(1);
        res_nxt        = '0;
        res_nxt.status = ST_OK;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    type_r    <= type_nxt;
    type_ok_r <= type_ok_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    cnt_r     <= cnt_nxt;
    base_r    <= base_nxt;
    idx_r     <= idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    found_r   <= found_nxt;
    best_r    <= best_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cnt_clr) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        list_cnt_r[i] <= '0;
      end
    end else if (cnt_we) begin
      list_cnt_r[type_r] <= cnt_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

endmodule

### tb/sv/tpsnq_nearest_checker.sv
// Checker for the typed point store: predicts each answer and compares every output transfer.
`timescale 1ns / 1ps
module tpsnq_nearest_checker
  import tpsnq_pkg::*;
#(
  parameter int NUM_TYPES     = 8,
  parameter int LIST_CAPACITY = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        errors,
  output int        due_count
);

  point_t      points [NUM_TYPES][LIST_CAPACITY];
  int unsigned list_len [NUM_TYPES];
  out_item_t   due_results [$];

  function automatic int unsigned coord_gap(input logic [COORD_BITS-1:0] a,
                                            input logic [COORD_BITS-1:0] b);
    return (a > b) ? 32'(a - b) : 32'(b - a);
  endfunction

  // Apply one action to the shadow lists and return the answer the block owes.
  function automatic out_item_t nearest_store_apply(input in_item_t item);
    out_item_t   res;
    int unsigned t;
    int unsigned n;
    int unsigned d;
    int unsigned best;
    bit          found;
    bit          hit;
    res        = '0;
    res.status = ST_OK;
    t          = 32'(item.res_type);
    if (item.action == ACT_CLEAR) begin
      foreach (list_len[i]) list_len[i] = 0;
    end else if (t >= NUM_TYPES) begin
      res.status = (item.action == ACT_INSERT) ? ST_FULL : ST_NONE;
    end else begin
      n = list_len[t];
      case (item.action)
        ACT_INSERT: begin
          if (n >= LIST_CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            points[t][n].x = item.coord_x;
            points[t][n].y = item.coord_y;
            list_len[t]    = n + 1;
          end
        end
        ACT_REMOVE: begin
          hit = 1'b0;
          for (int i = 0; i < n && !hit; i++) begin
            if (points[t][i].x == item.coord_x && points[t][i].y == item.coord_y) begin
              // fill the hole with the last entry
              points[t][i] = points[t][n-1];
              list_len[t]  = n - 1;
              hit          = 1'b1;
            end
          end
          res.status = hit ? ST_OK : ST_NONE;
        end
        default: begin
          found = 1'b0;
          best  = 0;
          for (int i = 0; i < n; i++) begin
            d = coord_gap(points[t][i].x, item.coord_x) + coord_gap(points[t][i].y, item.coord_y);
            // strict compare keeps the earliest entry on a tie
            if (!found || d < best) begin
              found      = 1'b1;
              best       = d;
              res.near_x = points[t][i].x;
              res.near_y = points[t][i].y;
            end
          end
          if (found) begin
            if (best > 2047) best = 2047;
            res.near_dist = best[10:0];
          end else begin
            res.status = ST_NONE;
          end
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (list_len[i]) list_len[i] = 0;
      due_results.delete();
      errors    = 0;
      due_count = 0;
    end else begin
      // the output transfer always belongs to an earlier input, so check it first
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result transfer: status %0d x %0d y %0d dist %0d",
                 out_data.status, out_data.near_x, out_data.near_y, out_data.near_dist);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.near_x !== want.near_x) begin
            $error("near_x: expected %0d, actual %0d", want.near_x, out_data.near_x);
            errors++;
          end
          if (out_data.near_y !== want.near_y) begin
            $error("near_y: expected %0d, actual %0d", want.near_y, out_data.near_y);
            errors++;
          end
          if (out_data.near_dist !== want.near_dist) begin
            $error("near_dist: expected %0d, actual %0d", want.near_dist, out_data.near_dist);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        due_results.insert(due_results.size(), nearest_store_apply(in_data));
      end
      due_count = due_results.size();
    end
  end

endmodule

### tb/sv/tb_typed_point_store_nearest_query.sv
// Testbench top: drives actions into the typed point store and reports the verdict.
`timescale 1ns / 1ps
module tb_typed_point_store_nearest_query;
  import tpsnq_pkg::*;

  localparam int N_TYPES    = 8;
  localparam int CAPACITY   = 256;
  localparam int RAND_ITEMS = 2000;
  localparam int FILL_ITEMS = 340;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        errors;
  int        due_count;
  bit        calm;
  point_t    last_pt [N_TYPES];

  typed_point_store_nearest_query #(
    .NUM_TYPES    (N_TYPES),
    .LIST_CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  tpsnq_nearest_checker #(
    .NUM_TYPES    (N_TYPES),
    .LIST_CAPACITY(CAPACITY)
  ) checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .errors   (errors),
    .due_count(due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 28);
  end

  function automatic in_item_t mk(input logic [1:0] act, input logic [2:0] t,
                                  input logic [9:0] x, input logic [9:0] y);
    in_item_t item;
    item.action   = act;
    item.res_type = t;
    item.coord_x  = x;
    item.coord_y  = y;
    return item;
  endfunction

  // Small set of coordinates so that duplicates, ties and remove hits are common.
  function automatic logic [9:0] crowded_coord();
    int unsigned k;
    k = $urandom_range(0, 7);
    return 10'((k < 5) ? k : 1016 + k);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input in_item_t item);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned r;
    logic [1:0]  act;
    logic [2:0]  t;
    logic [2:0]  fill_type;
    logic [9:0]  x;
    logic [9:0]  y;
    bit          wide;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    calm      = 1'b0;
    foreach (last_pt[i]) last_pt[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty lists, corners, ties, remove hits and misses, clear
    send_item(mk(ACT_QUERY,  3'd0, 10'd0,    10'd0));
    send_item(mk(ACT_REMOVE, 3'd0, 10'd0,    10'd0));
    send_item(mk(ACT_INSERT, 3'd0, 10'd0,    10'd0));
    send_item(mk(ACT_INSERT, 3'd0, 10'd1023, 10'd1023));
    send_item(mk(ACT_INSERT, 3'd0, 10'd512,  10'd0));
    send_item(mk(ACT_QUERY,  3'd0, 10'd1023, 10'd1023));
    send_item(mk(ACT_QUERY,  3'd0, 10'd0,    10'd1023));
    send_item(mk(ACT_QUERY,  3'd0, 10'd512,  10'd512));
    send_item(mk(ACT_REMOVE, 3'd0, 10'd5,    10'd5));
    send_item(mk(ACT_REMOVE, 3'd0, 10'd0,    10'd0));
    send_item(mk(ACT_QUERY,  3'd0, 10'd0,    10'd0));
    send_item(mk(ACT_INSERT, 3'd7, 10'd1023, 10'd0));
    send_item(mk(ACT_INSERT, 3'd7, 10'd1023, 10'd0));
    send_item(mk(ACT_REMOVE, 3'd7, 10'd1023, 10'd0));
    send_item(mk(ACT_QUERY,  3'd7, 10'd0,    10'd0));
    send_item(mk(ACT_REMOVE, 3'd7, 10'd1023, 10'd0));
    send_item(mk(ACT_QUERY,  3'd7, 10'd0,    10'd0));
    send_item(mk(ACT_INSERT, 3'd3, 10'd341,  10'd682));
    send_item(mk(ACT_QUERY,  3'd3, 10'd682,  10'd341));
    send_item(mk(ACT_CLEAR,  3'd5, 10'd1023, 10'd1023));
    send_item(mk(ACT_QUERY,  3'd0, 10'd0,    10'd0));
    send_item(mk(ACT_QUERY,  3'd3, 10'd341,  10'd682));

    fill_type = 3'($urandom_range(0, N_TYPES - 1));
    for (int k = 0; k < RAND_ITEMS; k++) begin
      calm = (k >= 1200 && k < 1500);
      if (k % 500 == 250) settle();
      r = $urandom_range(0, 99);
      x = 10'($urandom_range(0, 1023));
      y = 10'($urandom_range(0, 1023));
      t = 3'($urandom_range(0, N_TYPES - 1));
      if (k < FILL_ITEMS) begin
        // drive one list past capacity, with a few scans of the full list
        t = fill_type;
        if (r < 92) begin
          act = ACT_INSERT;
        end else if (r < 97) begin
          act = ACT_QUERY;
        end else begin
          act = ACT_REMOVE;
          x   = last_pt[t].x;
          y   = last_pt[t].y;
        end
      end else if (k == FILL_ITEMS) begin
        act = ACT_CLEAR;
      end else begin
        wide = ((k / 200) % 2) == 1;
        if (!wide) begin
          x = crowded_coord();
          y = crowded_coord();
          if ($urandom_range(0, 99) < 70) t = 3'($urandom_range(0, 1));
        end
        if (r < 40) begin
          act = ACT_INSERT;
        end else if (r < 65) begin
          act = ACT_REMOVE;
          if (wide && $urandom_range(0, 99) < 60) begin
            x = last_pt[t].x;
            y = last_pt[t].y;
          end
        end else if (r < 97) begin
          act = ACT_QUERY;
        end else begin
          act = ACT_CLEAR;
        end
      end
      if (act == ACT_INSERT) begin
        last_pt[t].x = x;
        last_pt[t].y = y;
      end
      send_item(mk(act, t, x, y));
    end
    calm = 1'b0;

    settle();
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
